// ===== rtl/core/tcb_pkg.sv =====
// shared types, command and result codes for the countdown timer bank
// no dependencies
package tcb_pkg;

    localparam int TCB_THREAD_SLOTS = 16;
    localparam int TCB_ALARM_SLOTS  = 8;
    localparam int TCB_TICKS_PER_MS = 10;
    localparam int TCB_COUNT_WIDTH  = 20;

    localparam int DELAY_W = 16;
    localparam int THR_W   = 4;
    localparam int TAG_W   = 16;

    // command codes
    localparam logic [2:0] CMD_TICK         = 3'd0;
    localparam logic [2:0] CMD_THREAD_DELAY = 3'd1;
    localparam logic [2:0] CMD_ALARM_INIT   = 3'd2;
    localparam logic [2:0] CMD_SET_DELAY    = 3'd3;
    localparam logic [2:0] CMD_START        = 3'd4;
    localparam logic [2:0] CMD_WAIT         = 3'd5;
    localparam logic [2:0] CMD_ENABLE_EVENT = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_THREAD = 2'd0;
    localparam logic [1:0] KIND_WAKE   = 2'd1;
    localparam logic [1:0] KIND_EVENT  = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [THR_W-1:0] thread;
        logic [TAG_W-1:0] event_id;
    } res_t;

    typedef struct packed {
        logic             is_alarm;
        logic [THR_W-1:0] thread;
        logic [TAG_W-1:0] tag;
        logic [THR_W-1:0] owner;
        logic             owner_valid;
    } step_info_t;

    typedef struct packed {
        logic write;
        logic emit;
        res_t res;
    } step_out_t;

endpackage

// ===== rtl/core/tick_countdown_timer_bank.sv =====
// top level of the countdown timer bank: counter storage, command decode and tick walk
// depends on tcb_pkg, tcb_scale and tcb_step_unit
//
// Thread delay counters and alarm channels counted down by a tick command. A tick
// walks all counter slots, threads then alarms, through one shared decrement unit
// at one slot per cycle while the output side does not hold results back. Each
// expiry that has a thread, an owner or an event tag to report gives one result
// transfer, the last one of a tick flagged by is_last. in_stall is high for the
// whole walk; the output register lets the last result drain while new commands
// are taken.
module tick_countdown_timer_bank
    import tcb_pkg::*;
#(
    parameter int THREAD_SLOTS = TCB_THREAD_SLOTS,
    parameter int ALARM_SLOTS  = TCB_ALARM_SLOTS,
    parameter int TICKS_PER_MS = TCB_TICKS_PER_MS,
    parameter int COUNT_WIDTH  = TCB_COUNT_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [THR_W-1:0]   current_thread,
    input  logic [2:0]         alarm_index,
    input  logic [DELAY_W-1:0] delay_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_kind,
    output logic [THR_W-1:0]   thread_index,
    output logic [TAG_W-1:0]   event_id,
    output logic               is_last
);

    localparam int TOTAL  = THREAD_SLOTS + ALARM_SLOTS;
    localparam int WALK_W = $clog2(TOTAL);
    localparam int TIDX_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int AIDX_W = (ALARM_SLOTS > 1) ? $clog2(ALARM_SLOTS) : 1;

    localparam logic [WALK_W-1:0] THR_BASE  = WALK_W'(THREAD_SLOTS);
    localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(TOTAL - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [WALK_W-1:0] walk_idx_reg;

    logic [COUNT_WIDTH-1:0] thread_cnt_reg [THREAD_SLOTS];
    logic [COUNT_WIDTH-1:0] alarm_rem_reg  [ALARM_SLOTS];
    logic [COUNT_WIDTH-1:0] alarm_rld_reg  [ALARM_SLOTS];
    logic [THR_W-1:0]       alarm_own_reg  [ALARM_SLOTS];
    logic                   alarm_ownv_reg [ALARM_SLOTS];
    logic [TAG_W-1:0]       alarm_tag_reg  [ALARM_SLOTS];
    logic [TAG_W-1:0]       next_tag_reg;

    logic pend_valid_reg;
    res_t pend_res_reg;
    logic out_valid_reg;
    res_t out_res_reg;
    logic out_last_reg;

    logic                   in_acc;
    logic                   walking;
    logic                   flushing;
    logic                   out_free;
    logic                   is_alarm_step;
    logic [TIDX_W-1:0]      t_walk;
    logic [AIDX_W-1:0]      a_walk;
    logic [AIDX_W-1:0]      a_cmd;
    logic [AIDX_W-1:0]      a_addr;
    logic                   thr_ok;
    logic                   alarm_ok;
    logic [COUNT_WIDTH-1:0] thread_delay;
    logic [COUNT_WIDTH-1:0] alarm_delay;
    logic [COUNT_WIDTH-1:0] step_count;
    logic [COUNT_WIDTH-1:0] new_count;
    step_info_t             info;
    step_out_t              step;
    logic                   step_fire;
    logic                   out_load;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign walking  = (state_reg == ST_WALK);
    assign flushing = (state_reg == ST_FLUSH);
    assign out_free = !out_valid_reg || !out_stall;

    assign is_alarm_step = (walk_idx_reg >= THR_BASE);
    assign t_walk        = TIDX_W'(walk_idx_reg);
    assign a_walk        = AIDX_W'(walk_idx_reg - THR_BASE);
    assign a_cmd         = AIDX_W'(alarm_index);
    assign a_addr        = walking ? a_walk : a_cmd;
    assign thr_ok        = (32'(current_thread) < THREAD_SLOTS);
    assign alarm_ok      = (32'(alarm_index) < ALARM_SLOTS);

    tcb_scale #(
        .FACTOR      (1),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_thread_scale (
        .delay_value (delay_value),
        .scaled      (thread_delay)
    );

    tcb_scale #(
        .FACTOR      (TICKS_PER_MS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_alarm_scale (
        .delay_value (delay_value),
        .scaled      (alarm_delay)
    );

    assign step_count       = is_alarm_step ? alarm_rem_reg[a_addr] : thread_cnt_reg[t_walk];
    assign info.is_alarm    = is_alarm_step;
    assign info.thread      = THR_W'(walk_idx_reg);
    assign info.tag         = alarm_tag_reg[a_addr];
    assign info.owner       = alarm_own_reg[a_addr];
    assign info.owner_valid = alarm_ownv_reg[a_addr];

    tcb_step_unit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .count     (step_count),
        .reload    (alarm_rld_reg[a_addr]),
        .info      (info),
        .new_count (new_count),
        .step      (step)
    );

    // a new expiry must wait while the held one cannot move on
    assign step_fire = walking && !(step.emit && pend_valid_reg && !out_free);
    assign out_load  = (step_fire && step.emit && pend_valid_reg)
                     || (flushing && pend_valid_reg && out_free);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (command == CMD_TICK))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (step_fire && (walk_idx_reg == WALK_LAST))
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                walk_idx_reg <= '0;
            end
            else if (step_fire)
            begin
                walk_idx_reg <= walk_idx_reg + WALK_W'(1);
            end
            if (step_fire && step.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flushing && out_free)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_fire && step.emit)
        begin
            pend_res_reg <= step.res;
        end
        if (out_load)
        begin
            out_res_reg  <= pend_res_reg;
            out_last_reg <= flushing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                thread_cnt_reg[i] <= '0;
            end
            for (int i = 0; i < ALARM_SLOTS; i++)
            begin
                alarm_rem_reg[i]  <= '0;
                alarm_rld_reg[i]  <= '0;
                alarm_own_reg[i]  <= '0;
                alarm_ownv_reg[i] <= 1'b0;
                alarm_tag_reg[i]  <= '0;
            end
            next_tag_reg <= TAG_W'(1);
        end
        else if (step_fire)
        begin
            if (step.write)
            begin
                if (is_alarm_step)
                begin
                    alarm_rem_reg[a_addr] <= new_count;
                end
                else
                begin
                    thread_cnt_reg[t_walk] <= new_count;
                end
            end
        end
        else if (in_acc)
        begin
            case (command)
                CMD_THREAD_DELAY:
                begin
                    if (thr_ok)
                    begin
                        thread_cnt_reg[TIDX_W'(current_thread)] <= thread_delay;
                    end
                end
                CMD_ALARM_INIT:
                begin
                    if (alarm_ok)
                    begin
                        alarm_rem_reg[a_addr]  <= '0;
                        alarm_rld_reg[a_addr]  <= alarm_delay;
                        alarm_own_reg[a_addr]  <= current_thread;
                        alarm_ownv_reg[a_addr] <= 1'b1;
                        alarm_tag_reg[a_addr]  <= '0;
                    end
                end
                CMD_SET_DELAY:
                begin
                    if (alarm_ok)
                    begin
                        alarm_rld_reg[a_addr] <= alarm_delay;
                    end
                end
                CMD_START:
                begin
                    if (alarm_ok)
                    begin
                        alarm_rem_reg[a_addr] <= alarm_rld_reg[a_addr];
                    end
                end
                CMD_WAIT:
                begin
                    if (alarm_ok)
                    begin
                        alarm_own_reg[a_addr]  <= current_thread;
                        alarm_ownv_reg[a_addr] <= 1'b1;
                        alarm_rem_reg[a_addr]  <= alarm_rld_reg[a_addr];
                    end
                end
                CMD_ENABLE_EVENT:
                begin
                    if (alarm_ok)
                    begin
                        alarm_tag_reg[a_addr] <= next_tag_reg;
                        next_tag_reg          <= next_tag_reg + TAG_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = out_res_reg.kind;
    assign thread_index = out_res_reg.thread;
    assign event_id     = out_res_reg.event_id;
    assign is_last      = out_last_reg;

    // no expiry is held back once the block takes commands again
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !pend_valid_reg)
        else $error("pending result left over after tick walk");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        walking |-> (walk_idx_reg <= WALK_LAST))
        else $error("walk index past last slot");

    a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.kind == KIND_EVENT)) |-> (out_res_reg.thread == '0))
        else $error("event result carries a thread index");

    a_tag_only_on_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (command != CMD_ENABLE_EVENT)) |=> $stable(next_tag_reg))
        else $error("event tag counter moved without enable command");

endmodule

// ===== rtl/core/tcb_scale.sv =====
// delay scaling with saturation to the counter width
// depends on tcb_pkg
module tcb_scale
    import tcb_pkg::*;
#(
    parameter int FACTOR      = TCB_TICKS_PER_MS,
    parameter int COUNT_WIDTH = TCB_COUNT_WIDTH
)
(
    input  logic [DELAY_W-1:0]     delay_value,
    output logic [COUNT_WIDTH-1:0] scaled
);

    localparam int FW = $clog2(FACTOR + 1);
    localparam int PW = DELAY_W + FW;
    localparam int CW = (PW > COUNT_WIDTH) ? PW : COUNT_WIDTH;

    logic [PW-1:0] prod;
    logic [CW-1:0] prod_ext;
    logic [CW-1:0] max_ext;

    assign prod     = PW'(delay_value) * PW'(FACTOR);
    assign prod_ext = CW'(prod);
    assign max_ext  = CW'({COUNT_WIDTH{1'b1}});
    assign scaled   = (prod_ext > max_ext) ? {COUNT_WIDTH{1'b1}} : COUNT_WIDTH'(prod_ext);

endmodule

// ===== rtl/core/tcb_step_unit.sv =====
// shared decrement and expiry unit, used once per counter slot of a tick walk
// depends on tcb_pkg
module tcb_step_unit
    import tcb_pkg::*;
#(
    parameter int COUNT_WIDTH = TCB_COUNT_WIDTH
)
(
    input  logic [COUNT_WIDTH-1:0] count,
    input  logic [COUNT_WIDTH-1:0] reload,
    input  step_info_t             info,
    output logic [COUNT_WIDTH-1:0] new_count,
    output step_out_t              step
);

    logic [COUNT_WIDTH-1:0] dec;
    logic                   hit;

    assign dec = count - COUNT_WIDTH'(1);
    assign hit = (count != '0) && (dec == '0);

    always_comb
    begin
        new_count          = dec;
        step.write         = (count != '0);
        step.emit          = 1'b0;
        step.res.kind      = KIND_THREAD;
        step.res.thread    = info.thread;
        step.res.event_id  = '0;
        if (info.is_alarm)
        begin
            step.res.thread = info.owner;
            step.res.kind   = KIND_WAKE;
            if (hit && (info.tag != '0))
            begin
                // periodic alarm posts its event and reloads
                new_count         = reload;
                step.emit         = 1'b1;
                step.res.kind     = KIND_EVENT;
                step.res.thread   = '0;
                step.res.event_id = info.tag;
            end
            else if (hit && info.owner_valid)
            begin
                step.emit = 1'b1;
            end
        end
        else
        begin
            step.emit = hit;
        end
    end

endmodule

// ===== verif/tb.sv =====
// testbench for tick_countdown_timer_bank: directed and random commands, results checked
// against an in-bench countdown predictor held in a small scoreboard class
// depends on tcb_pkg and the tick_countdown_timer_bank rtl
module tb;
    import tcb_pkg::*;

    localparam int THREADS        = TCB_THREAD_SLOTS;
    localparam int ALARMS         = TCB_ALARM_SLOTS;
    localparam int COUNT_W        = TCB_COUNT_WIDTH;
    localparam int WALK_CYCLES    = THREADS + ALARMS + 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 243;
    localparam int STEADY_FROM    = 205;

    // code the block does not decode
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic [1:0]       kind;
        logic [THR_W-1:0] thread;
        logic [TAG_W-1:0] event_id;
        logic             last;
    } expiry_t;

    class timer_bank_scoreboard;
        logic [COUNT_W-1:0] thread_count [THREADS];
        logic [COUNT_W-1:0] alarm_left   [ALARMS];
        logic [COUNT_W-1:0] alarm_reload [ALARMS];
        logic [THR_W-1:0]   alarm_owner  [ALARMS];
        logic               owner_valid  [ALARMS];
        logic [TAG_W-1:0]   alarm_tag    [ALARMS];
        logic [TAG_W-1:0]   next_tag;
        expiry_t            expiry_q [$];
        int                 errors;

        function new();
            for (int i = 0; i < THREADS; i++)
            begin
                thread_count[i] = '0;
            end
            for (int i = 0; i < ALARMS; i++)
            begin
                alarm_left[i]   = '0;
                alarm_reload[i] = '0;
                alarm_owner[i]  = '0;
                owner_valid[i]  = 1'b0;
                alarm_tag[i]    = '0;
            end
            next_tag = 16'd1;
            errors   = 0;
        endfunction

        function logic [COUNT_W-1:0] clamp_count(longint v);
            longint top;
            top = (longint'(1) << COUNT_W) - 1;
            return (v > top) ? top[COUNT_W-1:0] : v[COUNT_W-1:0];
        endfunction

        // one tick: threads in index order, then alarms
        function void walk_tick();
            expiry_t batch [THREADS + ALARMS];
            int      n;
            n = 0;
            for (int i = 0; i < THREADS; i++)
            begin
                if (thread_count[i] != 0)
                begin
                    thread_count[i] = thread_count[i] - 1'b1;
                    if (thread_count[i] == 0)
                    begin
                        batch[n] = '{KIND_THREAD, i[THR_W-1:0], '0, 1'b0};
                        n++;
                    end
                end
            end
            for (int i = 0; i < ALARMS; i++)
            begin
                if (alarm_left[i] != 0)
                begin
                    alarm_left[i] = alarm_left[i] - 1'b1;
                    if (alarm_left[i] == 0)
                    begin
                        if (alarm_tag[i] != 0)
                        begin
                            alarm_left[i] = alarm_reload[i];
                            batch[n] = '{KIND_EVENT, '0, alarm_tag[i], 1'b0};
                            n++;
                        end
                        else if (owner_valid[i])
                        begin
                            batch[n] = '{KIND_WAKE, alarm_owner[i], '0, 1'b0};
                            n++;
                        end
                    end
                end
            end
            if (n > 0)
            begin
                batch[n-1].last = 1'b1;
            end
            for (int k = 0; k < n; k++)
            begin
                expiry_q.push_back(batch[k]);
            end
        endfunction

        function void note_command(logic [2:0] cmd, logic [THR_W-1:0] thr,
                                   logic [2:0] ai, logic [DELAY_W-1:0] dly);
            logic [COUNT_W-1:0] scaled;
            logic               alarm_ok;
            scaled   = clamp_count(longint'(dly) * TCB_TICKS_PER_MS);
            alarm_ok = (int'(ai) < ALARMS);
            case (cmd)
                CMD_TICK:
                begin
                    walk_tick();
                end
                CMD_THREAD_DELAY:
                begin
                    if (int'(thr) < THREADS)
                    begin
                        thread_count[thr] = clamp_count(longint'(dly));
                    end
                end
                CMD_ALARM_INIT:
                begin
                    if (alarm_ok)
                    begin
                        alarm_left[ai]   = '0;
                        alarm_reload[ai] = scaled;
                        alarm_owner[ai]  = thr;
                        owner_valid[ai]  = 1'b1;
                        alarm_tag[ai]    = '0;
                    end
                end
                CMD_SET_DELAY:
                begin
                    if (alarm_ok)
                    begin
                        alarm_reload[ai] = scaled;
                    end
                end
                CMD_START:
                begin
                    if (alarm_ok)
                    begin
                        alarm_left[ai] = alarm_reload[ai];
                    end
                end
                CMD_WAIT:
                begin
                    if (alarm_ok)
                    begin
                        alarm_owner[ai] = thr;
                        owner_valid[ai] = 1'b1;
                        alarm_left[ai]  = alarm_reload[ai];
                    end
                end
                CMD_ENABLE_EVENT:
                begin
                    if (alarm_ok)
                    begin
                        alarm_tag[ai] = next_tag;
                        next_tag      = next_tag + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [THR_W-1:0] thr,
                                   logic [TAG_W-1:0] ev, logic last);
            expiry_t exp_r;
            if (expiry_q.size() == 0)
            begin
                $error("result with nothing expected: kind %0d thread %0d event %0d last %0d",
                       kind, thr, ev, last);
                errors++;
                return;
            end
            exp_r = expiry_q.pop_front();
            if (kind !== exp_r.kind)
            begin
                $error("result_kind: expected %0d, got %0d", exp_r.kind, kind);
                errors++;
            end
            if (thr !== exp_r.thread)
            begin
                $error("thread_index: expected %0d, got %0d", exp_r.thread, thr);
                errors++;
            end
            if (ev !== exp_r.event_id)
            begin
                $error("event_id: expected %0d, got %0d", exp_r.event_id, ev);
                errors++;
            end
            if (last !== exp_r.last)
            begin
                $error("is_last: expected %0d, got %0d", exp_r.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expiry_q.size();
        endfunction
    endclass

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic [2:0]         command        = '0;
    logic [THR_W-1:0]   current_thread = '0;
    logic [2:0]         alarm_index    = '0;
    logic [DELAY_W-1:0] delay_value    = '0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic [1:0]         result_kind;
    logic [THR_W-1:0]   thread_index;
    logic [TAG_W-1:0]   event_id;
    logic               is_last;

    timer_bank_scoreboard sb;
    bit steady    = 1'b0;
    bit hold_arm  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;

    tick_countdown_timer_bank u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .current_thread (current_thread),
        .alarm_index    (alarm_index),
        .delay_value    (delay_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .thread_index   (thread_index),
        .event_id       (event_id),
        .is_last        (is_last)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_command(command, current_thread, alarm_index, delay_value);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(result_kind, thread_index, event_id, is_last);
            end
        end
    end

    // cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stall bursts, plus one long hold-off to back up the block
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (hold_arm && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            else if (!steady && $urandom_range(0, 9) == 0)
            begin
                hold_left = $urandom_range(1, 15);
            end
            out_stall <= (hold_left > 0);
        end
    end

    task automatic issue_command(logic [2:0] cmd, logic [THR_W-1:0] thr,
                                 logic [2:0] ai, logic [DELAY_W-1:0] dly);
        int gap;
        @(negedge clk);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        command        <= cmd;
        current_thread <= thr;
        alarm_index    <= ai;
        delay_value    <= dly;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [DELAY_W-1:0] pick_alarm_ms();
        if ($urandom_range(0, 3) != 0)
        begin
            return DELAY_W'($urandom_range(0, 3));
        end
        return DELAY_W'($urandom_range(0, 65535));
    endfunction

    task automatic random_command();
        int               pick;
        logic [THR_W-1:0] thr;
        logic [2:0]       ai;
        logic [DELAY_W-1:0] dly;
        pick = $urandom_range(0, 99);
        thr  = THR_W'($urandom_range(0, 15));
        ai   = 3'($urandom_range(0, 7));
        if (pick < 40)
        begin
            issue_command(CMD_TICK, thr, ai, DELAY_W'($urandom_range(0, 65535)));
        end
        else if (pick < 58)
        begin
            case ($urandom_range(0, 9))
                0:       dly = '0;
                1, 2:    dly = DELAY_W'($urandom_range(0, 65535));
                default: dly = DELAY_W'($urandom_range(1, 12));
            endcase
            issue_command(CMD_THREAD_DELAY, thr, ai, dly);
        end
        else if (pick < 66)
        begin
            issue_command(CMD_ALARM_INIT, thr, ai, pick_alarm_ms());
        end
        else if (pick < 73)
        begin
            issue_command(CMD_SET_DELAY, thr, ai, pick_alarm_ms());
        end
        else if (pick < 81)
        begin
            issue_command(CMD_START, thr, ai, DELAY_W'($urandom_range(0, 65535)));
        end
        else if (pick < 89)
        begin
            issue_command(CMD_WAIT, thr, ai, DELAY_W'($urandom_range(0, 65535)));
        end
        else if (pick < 97)
        begin
            issue_command(CMD_ENABLE_EVENT, thr, ai, DELAY_W'($urandom_range(0, 65535)));
        end
        else
        begin
            issue_command(CMD_UNUSED, thr, ai, DELAY_W'($urandom_range(0, 65535)));
        end
    endtask

    initial
    begin
        int sent;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty tick, unused code, field extremes
        issue_command(CMD_TICK, 4'd0, 3'd0, 16'd0);
        issue_command(CMD_UNUSED, 4'd15, 3'd7, 16'hFFFF);
        issue_command(CMD_THREAD_DELAY, 4'd0, 3'd0, 16'd1);
        issue_command(CMD_THREAD_DELAY, 4'd15, 3'd7, 16'd2);
        issue_command(CMD_THREAD_DELAY, 4'd5, 3'd0, 16'd0);
        issue_command(CMD_THREAD_DELAY, 4'd9, 3'd0, 16'hFFFF);
        issue_command(CMD_TICK, 4'd0, 3'd0, 16'd0);
        issue_command(CMD_TICK, 4'd0, 3'd0, 16'd0);
        // wake-owner alarm whose owner is replaced by a wait
        issue_command(CMD_ALARM_INIT, 4'd3, 3'd0, 16'd1);
        issue_command(CMD_WAIT, 4'd12, 3'd0, 16'd0);
        // periodic alarm, widest delay then shortened
        issue_command(CMD_ALARM_INIT, 4'd15, 3'd7, 16'hFFFF);
        issue_command(CMD_SET_DELAY, 4'd0, 3'd7, 16'd1);
        issue_command(CMD_ENABLE_EVENT, 4'd0, 3'd7, 16'd0);
        issue_command(CMD_START, 4'd0, 3'd7, 16'd0);
        // never initialised: no owner, expires silently
        issue_command(CMD_SET_DELAY, 4'd0, 3'd5, 16'd1);
        issue_command(CMD_START, 4'd0, 3'd5, 16'd0);
        issue_command(CMD_THREAD_DELAY, 4'd3, 3'd0, 16'd10);
        repeat (10) issue_command(CMD_TICK, 4'd0, 3'd0, 16'd0);

        hold_arm = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= STEADY_FROM)
            begin
                steady = 1'b1;
            end
            random_command();
            sent++;
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * WALK_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== tick_countdown_timer_bank.f =====
rtl/core/tcb_pkg.sv
rtl/core/tcb_scale.sv
rtl/core/tcb_step_unit.sv
rtl/core/tick_countdown_timer_bank.sv
verif/tb.sv
